>>> rtl/cidf_pkg.sv
// Shared types and constants of the CAN identifier acceptance filter bank.
// No dependencies; the slot matcher and the top level use it by scoped names.
package cidf_pkg;

  // Item kinds carried on the input tuser bit.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // Fixed sizes of the stream fields.
  localparam int BANK_SLOTS = 16;
  localparam int SLOT_W     = 4;
  localparam int FIELD_W    = 29;
  localparam int MASK_W     = 16;
  localparam int COUNT_W    = 5;

  // Bit positions of the input fields in s_tdata.
  localparam int IN_SLOT_LSB   = 0;
  localparam int IN_ENABLE_BIT = 4;
  localparam int IN_FD_BIT     = 5;
  localparam int IN_EXT_BIT    = 6;
  localparam int IN_REMOTE_BIT = 7;
  localparam int IN_RANGE_BIT  = 8;
  localparam int IN_FIRST_LSB  = 9;
  localparam int IN_SECOND_LSB = 38;
  localparam int IN_ID_LSB     = 67;
  localparam int IN_DATA_W     = 96;
  localparam int OUT_DATA_W    = 24;

  // Class and format flags of a filter slot or of a received frame.
  typedef struct packed {
    logic fd;
    logic ext;
    logic remote;
    logic range_mode;
  } flt_flags_t;

  localparam int FLAG_W = $bits(flt_flags_t);

endpackage

>>> rtl/cidf_entry_match.sv
// Acceptance test of one stored filter slot against one received frame.
// Depends on cidf_pkg for the flag struct.
module cidf_entry_match #(
  parameter int ID_WIDTH = 29
) (
  input  logic                   entry_valid,
  input  cidf_pkg::flt_flags_t   entry_flags,
  input  logic [ID_WIDTH-1:0]    entry_lo,
  input  logic [ID_WIDTH-1:0]    entry_hi,
  input  cidf_pkg::flt_flags_t   frame_flags,
  input  logic [ID_WIDTH-1:0]    frame_id,
  output logic                   hit
);

  logic class_ok;
  logic id_ok;

  // The remote flag only counts for classic frames.
  assign class_ok = entry_valid
                    && (entry_flags.fd == frame_flags.fd)
                    && (entry_flags.ext == frame_flags.ext)
                    && (frame_flags.fd || (entry_flags.remote == frame_flags.remote));

  // Range mode is inclusive at both ends; an inverted range accepts nothing.
  assign id_ok = entry_flags.range_mode ? ((frame_id >= entry_lo) && (frame_id <= entry_hi))
                                        : ((frame_id & entry_lo) == entry_hi);

  assign hit = class_ok && id_ok;

endmodule

>>> rtl/can_id_acceptance_filter_unit.sv
// Top level of the CAN identifier acceptance filter bank.
// Depends on cidf_pkg and instantiates cidf_entry_match.

// The block holds a bank of filter slots in a synchronous memory with one write and one read
// port. Each slot also has one valid flip-flop, so reset leaves every slot invalid at once and
// no clearing pass is needed. A write beat (tuser 0) produces no result. A
// write with slot_enable 0 invalidates the slot, and a write to a slot at or beyond NUM_FILTERS
// is dropped. A frame beat (tuser 1) starts a walk over the slots, one memory read per cycle.
// The read address rests on slot 0 while idle, so slot 0 is read at the accepting edge itself.
// The result is then loaded: each slot goes through the matcher in turn, and then the result
// moves into the output register once that is free or being emptied. The input is ready again
// in the cycle after the load, so no new beat is taken before a walk has finished and its
// result is loaded. The result beat waits in the output register while the next input beat is
// taken; the input is held off only while a walk is running or while a finished result cannot
// yet move into an occupied output register.
module can_id_acceptance_filter_unit #(
  parameter int NUM_FILTERS = 16,
  parameter int ID_WIDTH    = 29
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // Fields from bit 0 up: slot[3:0], slot_enable, frame_is_fd, ext_format, remote,
  // range_mode, first_value[28:0], second_value[28:0], frame_id[28:0].
  input  logic [cidf_pkg::IN_DATA_W-1:0]  s_tdata,
  // Fields from bit 0 up: kind.
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // Fields from bit 0 up: match_mask[15:0], match_count[4:0], any_match, two zero bits.
  output logic [cidf_pkg::OUT_DATA_W-1:0] m_tdata
);

  // Slots that exist in the bank and take part in matching.
  localparam int ACTIVE  = (NUM_FILTERS < cidf_pkg::BANK_SLOTS) ? NUM_FILTERS
                                                                 : cidf_pkg::BANK_SLOTS;
  localparam int AW      = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
  localparam int ENTRY_W = cidf_pkg::FLAG_W + 2 * ID_WIDTH;
  localparam logic [AW-1:0] LAST_SLOT = AW'(ACTIVE - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state;

  // Filter memory: {flags, lower value, upper value} per slot, no reset.
  logic [ENTRY_W-1:0] filter_mem [ACTIVE];
  logic [ACTIVE-1:0]  slot_valid;

  logic [AW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               rd_valid;

  // Decoded input beat.
  logic [cidf_pkg::SLOT_W-1:0] in_slot;
  logic                        in_enable;
  cidf_pkg::flt_flags_t        in_flags;
  logic [ID_WIDTH-1:0]         in_lo;
  logic [ID_WIDTH-1:0]         in_hi;
  logic [ID_WIDTH-1:0]         in_id;
  logic                        in_accept;
  logic                        slot_ok;

  // Frame under test and the running result.
  cidf_pkg::flt_flags_t          frame_flags;
  logic [ID_WIDTH-1:0]           frame_id;
  logic [AW-1:0]                 eval_idx;
  logic [cidf_pkg::MASK_W-1:0]   acc_mask;
  logic [cidf_pkg::COUNT_W-1:0]  acc_count;
  logic [cidf_pkg::MASK_W-1:0]   acc_mask_next;
  logic [cidf_pkg::COUNT_W-1:0]  acc_count_next;

  cidf_pkg::flt_flags_t rd_flags;
  logic [ID_WIDTH-1:0]  rd_lo;
  logic [ID_WIDTH-1:0]  rd_hi;
  logic                 slot_hit;

  assign in_slot             = s_tdata[cidf_pkg::IN_SLOT_LSB +: cidf_pkg::SLOT_W];
  assign in_enable           = s_tdata[cidf_pkg::IN_ENABLE_BIT];
  assign in_flags.fd         = s_tdata[cidf_pkg::IN_FD_BIT];
  assign in_flags.ext        = s_tdata[cidf_pkg::IN_EXT_BIT];
  assign in_flags.remote     = s_tdata[cidf_pkg::IN_REMOTE_BIT];
  assign in_flags.range_mode = s_tdata[cidf_pkg::IN_RANGE_BIT];
  // Values are cut to the identifier width before they are stored or compared.
  assign in_lo               = s_tdata[cidf_pkg::IN_FIRST_LSB +: ID_WIDTH];
  assign in_hi               = s_tdata[cidf_pkg::IN_SECOND_LSB +: ID_WIDTH];
  assign in_id               = s_tdata[cidf_pkg::IN_ID_LSB +: ID_WIDTH];

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign slot_ok   = (int'(in_slot) < NUM_FILTERS);

  // The walk reads slot 0 while idle, so its data is ready in the first scan cycle, and
  // then fetches the slot after the one being evaluated, or slot 0 at the last slot.
  always_comb begin
    rd_addr = '0;
    if (state == ST_SCAN && eval_idx != LAST_SLOT) begin
      rd_addr = eval_idx + 1'b1;
    end
  end

  // Writes happen only while idle and reads matter only while scanning, so the two
  // never touch the same entry in an overlapping way.
  always_ff @(posedge clk) begin
    if (in_accept && s_tuser == cidf_pkg::KIND_WRITE && slot_ok) begin
      if (in_enable) begin
        filter_mem[in_slot[AW-1:0]] <= {in_flags, in_lo, in_hi};
      end else begin
        filter_mem[in_slot[AW-1:0]] <= '0;
      end
    end
    rd_data <= filter_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (in_accept && s_tuser == cidf_pkg::KIND_WRITE && slot_ok) begin
        slot_valid[in_slot[AW-1:0]] <= in_enable;
      end
      rd_valid <= slot_valid[rd_addr];
    end
  end

  assign rd_flags = rd_data[ENTRY_W-1 -: cidf_pkg::FLAG_W];
  assign rd_lo    = rd_data[ID_WIDTH +: ID_WIDTH];
  assign rd_hi    = rd_data[0 +: ID_WIDTH];

  cidf_entry_match #(
    .ID_WIDTH (ID_WIDTH)
  ) u_match (
    .entry_valid (rd_valid),
    .entry_flags (rd_flags),
    .entry_lo    (rd_lo),
    .entry_hi    (rd_hi),
    .frame_flags (frame_flags),
    .frame_id    (frame_id),
    .hit         (slot_hit)
  );

  // Fold the current slot's verdict into the bitmap and the count.
  always_comb begin
    acc_mask_next  = acc_mask;
    acc_count_next = acc_count;
    if (slot_hit) begin
      acc_mask_next  = acc_mask | (cidf_pkg::MASK_W'(1) << eval_idx);
      acc_count_next = acc_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      eval_idx  <= '0;
      acc_mask  <= '0;
      acc_count <= '0;
    end else begin
      // The output register fills when a finished walk finds it free or being emptied.
      if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept && s_tuser == cidf_pkg::KIND_FRAME) begin
            frame_flags <= in_flags;
            frame_id    <= in_id;
            eval_idx    <= '0;
            acc_mask    <= '0;
            acc_count   <= '0;
            state       <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          acc_mask  <= acc_mask_next;
          acc_count <= acc_count_next;
          eval_idx  <= rd_addr;
          if (eval_idx == LAST_SLOT) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Load the result once the output register is free or being emptied.
          if (!m_tvalid || m_tready) begin
            m_tdata <= {2'b00, (acc_count != '0), acc_count, acc_mask};
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> verif/can_id_acceptance_filter_checker.sv
// Checker of the CAN identifier acceptance filter bank: watches both streams, predicts each
// frame verdict from its own copy of the filter slots and compares the result beats.
// Depends on cidf_pkg for field positions and widths.
`timescale 1ns / 1ps

module filter_verdict_checker #(
  parameter int NUM_FILTERS = 16,
  parameter int ID_WIDTH    = 29
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [cidf_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [cidf_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                              mismatches,
  output int                              verdicts_outstanding
);
  import cidf_pkg::*;

  localparam int LIVE_SLOTS = (NUM_FILTERS < BANK_SLOTS) ? NUM_FILTERS : BANK_SLOTS;
  localparam logic [FIELD_W-1:0] ID_KEEP = FIELD_W'((64'd1 << ID_WIDTH) - 64'd1);

  typedef struct packed {
    logic               valid;
    flt_flags_t         flags;
    logic [FIELD_W-1:0] first;
    logic [FIELD_W-1:0] second;
  } slot_entry_t;

  typedef struct packed {
    logic               any;
    logic [COUNT_W-1:0] count;
    logic [MASK_W-1:0]  mask;
  } verdict_t;

  slot_entry_t filter_slots [BANK_SLOTS];
  verdict_t    pending_verdicts [$];

  // A slot accepts when class and format agree, the remote flag agrees on classic frames,
  // and the id passes the mask compare or lies inside the inclusive range.
  function automatic verdict_t predict_verdict(input flt_flags_t f, input logic [FIELD_W-1:0] id);
    verdict_t v;
    slot_entry_t e;
    v = '0;
    for (int i = 0; i < LIVE_SLOTS; i++) begin
      e = filter_slots[i];
      if (e.valid && e.flags.fd == f.fd && e.flags.ext == f.ext &&
          (f.fd || e.flags.remote == f.remote) &&
          (e.flags.range_mode ? (id >= e.first && id <= e.second)
                              : ((id & e.first) == e.second))) begin
        v.mask[i] = 1'b1;
        v.count   = v.count + 1'b1;
      end
    end
    v.any = (v.count != '0);
    return v;
  endfunction

  always @(posedge clk) begin : track
    logic [SLOT_W-1:0] slot;
    flt_flags_t        f;
    verdict_t          seen;
    verdict_t          want;
    if (rst) begin
      for (int i = 0; i < BANK_SLOTS; i++) filter_slots[i] = '0;
      pending_verdicts.delete();
      mismatches = 0;
    end else begin
      // Result side first; a result can never belong to the beat taken at the same edge.
      if (m_tvalid && m_tready) begin
        seen.mask  = m_tdata[MASK_W-1:0];
        seen.count = m_tdata[MASK_W +: COUNT_W];
        seen.any   = m_tdata[MASK_W + COUNT_W];
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with none expected: mask %h count %0d any %0d",
                     $realtime, seen.mask, seen.count, seen.any);
        end else begin
          want = pending_verdicts.pop_front();
          if (seen.mask !== want.mask || seen.count !== want.count || seen.any !== want.any) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: verdict mismatch: expected mask %h count %0d any %0d",
                       $realtime, want.mask, want.count, want.any);
              $display("  got mask %h count %0d any %0d", seen.mask, seen.count, seen.any);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        slot = s_tdata[IN_SLOT_LSB +: SLOT_W];
        f.fd         = s_tdata[IN_FD_BIT];
        f.ext        = s_tdata[IN_EXT_BIT];
        f.remote     = s_tdata[IN_REMOTE_BIT];
        f.range_mode = s_tdata[IN_RANGE_BIT];
        if (s_tuser == KIND_FRAME) begin
          pending_verdicts.push_back(predict_verdict(f, s_tdata[IN_ID_LSB +: FIELD_W] & ID_KEEP));
        end else if (int'(slot) < LIVE_SLOTS) begin
          filter_slots[slot] = '0;
          if (s_tdata[IN_ENABLE_BIT]) begin
            filter_slots[slot].valid  = 1'b1;
            filter_slots[slot].flags  = f;
            filter_slots[slot].first  = s_tdata[IN_FIRST_LSB +: FIELD_W] & ID_KEEP;
            filter_slots[slot].second = s_tdata[IN_SECOND_LSB +: FIELD_W] & ID_KEEP;
          end
        end
      end
    end
    verdicts_outstanding <= pending_verdicts.size();
  end

endmodule

>>> verif/tb_can_id_acceptance_filter_unit.sv
// Testbench top of the CAN identifier acceptance filter bank: clock, reset, directed and random
// filter writes and frames, random back-pressure, watchdog and verdict.
// Depends on cidf_pkg, can_id_acceptance_filter_unit and filter_verdict_checker.
`timescale 1ns / 1ps

module tb_can_id_acceptance_filter_unit;
  import cidf_pkg::*;

  localparam int NUM_FILTERS     = 16;
  localparam int ID_WIDTH        = 29;
  localparam int RANDOM_ITEMS    = 2000;
  localparam int HOLD_OFF_CYCLES = 400;
  // The drain wait and the watchdog allow for far more time than a frame's walk takes.
  localparam int DRAIN_CYCLES    = 40;
  localparam int QUIET_LIMIT     = 3000;
  localparam logic [FIELD_W-1:0] ALL_ONES = '1;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  int mismatches;
  int verdicts_outstanding;
  int quiet_cycles;

  // Stimulus controls shared with the receiver process.
  logic steady_phase = 1'b0;
  logic hold_off_go  = 1'b0;
  logic hold_off_done = 1'b0;

  // Last settings written per slot, used only to aim frames at likely hits.
  flt_flags_t         last_flags  [BANK_SLOTS];
  logic [FIELD_W-1:0] last_first  [BANK_SLOTS];
  logic [FIELD_W-1:0] last_second [BANK_SLOTS];

  can_id_acceptance_filter_unit #(
    .NUM_FILTERS(NUM_FILTERS),
    .ID_WIDTH   (ID_WIDTH)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  filter_verdict_checker #(
    .NUM_FILTERS(NUM_FILTERS),
    .ID_WIDTH   (ID_WIDTH)
  ) verdict_check (
    .clk                 (clk),
    .rst                 (rst),
    .s_tvalid            (s_tvalid),
    .s_tready            (s_tready),
    .s_tdata             (s_tdata),
    .s_tuser             (s_tuser),
    .m_tvalid            (m_tvalid),
    .m_tready            (m_tready),
    .m_tdata             (m_tdata),
    .mismatches          (mismatches),
    .verdicts_outstanding(verdicts_outstanding)
  );

  always #5 clk = ~clk;

  function automatic logic [FIELD_W-1:0] any_field();
    return FIELD_W'($urandom());
  endfunction

  function automatic flt_flags_t flags_of(input logic fd, input logic ext, input logic rtr,
                                          input logic rng);
    flt_flags_t f;
    f.fd         = fd;
    f.ext        = ext;
    f.remote     = rtr;
    f.range_mode = rng;
    return f;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_item(
    input logic [SLOT_W-1:0]  slot,
    input logic               enable,
    input flt_flags_t         f,
    input logic [FIELD_W-1:0] first,
    input logic [FIELD_W-1:0] second,
    input logic [FIELD_W-1:0] id
  );
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[IN_SLOT_LSB +: SLOT_W]    = slot;
    d[IN_ENABLE_BIT]            = enable;
    d[IN_FD_BIT]                = f.fd;
    d[IN_EXT_BIT]               = f.ext;
    d[IN_REMOTE_BIT]            = f.remote;
    d[IN_RANGE_BIT]             = f.range_mode;
    d[IN_FIRST_LSB +: FIELD_W]  = first;
    d[IN_SECOND_LSB +: FIELD_W] = second;
    d[IN_ID_LSB +: FIELD_W]     = id;
    return d;
  endfunction

  // Offers one beat and returns at the edge that takes it. Ready is sampled on the falling
  // edge, where it is settled, so the decision never races the rising edge.
  task automatic send_beat(input logic kind, input logic [IN_DATA_W-1:0] data);
    logic taken;
    if (!steady_phase && $urandom_range(0, 99) < 12) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= kind;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end
  endtask

  task automatic write_filter(input logic [SLOT_W-1:0] slot, input logic enable,
                              input flt_flags_t f, input logic [FIELD_W-1:0] first,
                              input logic [FIELD_W-1:0] second);
    last_flags[slot]  = f;
    last_first[slot]  = first;
    last_second[slot] = second;
    send_beat(KIND_WRITE, pack_item(slot, enable, f, first, second, any_field()));
  endtask

  // Frame beats carry noise in the fields that only a write uses.
  task automatic classify_frame(input flt_flags_t f, input logic [FIELD_W-1:0] id);
    send_beat(KIND_FRAME, pack_item(SLOT_W'($urandom_range(0, BANK_SLOTS - 1)),
                                    1'($urandom_range(0, 1)), f, any_field(), any_field(), id));
  endtask

  // Result side: random stalls, one long hold-off that lets the block fill up, and no
  // stalls at all during the steady phase.
  initial begin
    m_tready <= 1'b0;
    forever begin
      if (hold_off_go && !hold_off_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        m_tready <= steady_phase || ($urandom_range(0, 99) >= 12);
        @(posedge clk);
      end
    end
  end

  // Watchdog on cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("can_id_acceptance_filter_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= KIND_WRITE;
    for (int i = 0; i < BANK_SLOTS; i++) begin
      last_flags[i]  = '0;
      last_first[i]  = '0;
      last_second[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Frame against an empty bank.
    classify_frame(flags_of(1'b1, 1'b1, 1'b1, 1'b0), ALL_ONES);
    // Every slot catches all classic standard data frames: even slots by a zero mask,
    // odd slots by the full range. Both id extremes must hit all sixteen.
    for (int i = 0; i < BANK_SLOTS; i++)
      write_filter(SLOT_W'(i), 1'b1, flags_of(1'b0, 1'b0, 1'b0, 1'(i % 2)), '0,
                   (i % 2 == 1) ? ALL_ONES : '0);
    classify_frame(flags_of(1'b0, 1'b0, 1'b0, 1'b0), '0);
    classify_frame(flags_of(1'b0, 1'b0, 1'b0, 1'b1), ALL_ONES);
    // A classic remote frame disagrees with every slot.
    classify_frame(flags_of(1'b0, 1'b0, 1'b1, 1'b0), 29'h2A5);
    // Disabling a slot clears it even with other fields set.
    write_filter(SLOT_W'(5), 1'b0, flags_of(1'b1, 1'b1, 1'b1, 1'b1), ALL_ONES, ALL_ONES);
    classify_frame(flags_of(1'b0, 1'b0, 1'b0, 1'b0), 29'h155);
    // Empty range on an FD extended slot; remote flag ignored on an FD mask slot.
    write_filter(SLOT_W'(7), 1'b1, flags_of(1'b1, 1'b1, 1'b1, 1'b1), ALL_ONES, '0);
    write_filter(SLOT_W'(9), 1'b1, flags_of(1'b1, 1'b0, 1'b1, 1'b0), ALL_ONES, 29'h5A5);
    classify_frame(flags_of(1'b1, 1'b0, 1'b0, 1'b0), 29'h5A5);
    classify_frame(flags_of(1'b1, 1'b1, 1'b0, 1'b0), '0);
    // Single-point range on a classic extended remote slot.
    write_filter(SLOT_W'(3), 1'b1, flags_of(1'b0, 1'b1, 1'b1, 1'b1), 29'h1234567, 29'h1234567);
    classify_frame(flags_of(1'b0, 1'b1, 1'b1, 1'b0), 29'h1234567);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin : random_items
      logic [SLOT_W-1:0]  s;
      flt_flags_t         f;
      logic [FIELD_W-1:0] a;
      logic [FIELD_W-1:0] b;
      logic [FIELD_W-1:0] id;
      int                 pick;
      steady_phase = (n >= 1200 && n < 1500);
      if (n == 600) hold_off_go = 1'b1;
      s = SLOT_W'($urandom_range(0, BANK_SLOTS - 1));
      if ($urandom_range(0, 99) < 45) begin
        f = flt_flags_t'(4'($urandom_range(0, 15)));
        if (f.range_mode) begin
          a = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom_range(0, 4095)) : any_field();
          pick = $urandom_range(0, 99);
          if (pick < 60)      b = a + FIELD_W'($urandom_range(0, 255));
          else if (pick < 85) b = any_field();
          else                b = ALL_ONES;
        end else begin
          case ($urandom_range(0, 4))
            0:       a = any_field();
            1:       a = any_field() & any_field();
            2:       a = ALL_ONES;
            3:       a = '0;
            default: a = FIELD_W'($urandom_range(0, 2047));
          endcase
          b = ($urandom_range(0, 99) < 80) ? (any_field() & a) : any_field();
        end
        write_filter(s, $urandom_range(0, 99) < 90, f, a, b);
      end else begin
        // Mostly frames aimed at the last setting of a random slot, with boundary and
        // near-miss ids; the rest are fully random frames.
        f = last_flags[s];
        a = last_first[s];
        b = last_second[s];
        if ($urandom_range(0, 99) < 30) begin
          f  = flt_flags_t'(4'($urandom_range(0, 15)));
          id = any_field();
        end else if (f.range_mode) begin
          case ($urandom_range(0, 4))
            0:       id = a;
            1:       id = b;
            2:       id = a - 1'b1;
            3:       id = b + 1'b1;
            default: id = (b >= a) ? a + FIELD_W'($urandom % (32'(b - a) + 32'd1)) : any_field();
          endcase
        end else begin
          id = b | (any_field() & ~a);
          if ($urandom_range(0, 3) == 0)
            id = id ^ (FIELD_W'(1) << $urandom_range(0, FIELD_W - 1));
        end
        f.range_mode = 1'($urandom_range(0, 1));
        if (f.fd) f.remote = 1'($urandom_range(0, 1));
        classify_frame(f, id);
      end
    end

    s_tvalid <= 1'b0;
    steady_phase = 1'b0;
    @(posedge clk);
    while (verdicts_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("can_id_acceptance_filter_unit test passed");
    end else begin
      $display("can_id_acceptance_filter_unit test failed");
    end
    $finish;
  end

endmodule
